/* sv/etf_pkg.sv */
// ----------------------------------------------------------------------------
// etf_pkg: shared definitions for the edge-tracking tape follower
// Fixed-point widths, register indexes and the divider status bundle.
// ----------------------------------------------------------------------------
package etf_pkg;

	// Fraction bits of the balance integral and the dwell ratio
	localparam int FRAC_BITS  = 16;
	// Bits of time kept from the sample time
	localparam int TIME_WIDTH = 32;

	// Balance integral: signed, integer part covers -8 .. just under +8
	localparam int INT_W      = FRAC_BITS + 4;
	// Quotient of the dwell ratio: 0 .. 1.0 inclusive
	localparam int QUOT_W     = FRAC_BITS + 1;
	// Divider remainder: divisor is TIME_WIDTH+1 bits, plus one for the shift
	localparam int REM_W      = TIME_WIDTH + 2;
	localparam int DIV_STEPS  = FRAC_BITS + 1;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam int GAIN_W     = 16;
	localparam int SENSOR_W   = 10;

	localparam logic signed [INT_W-1:0] INT_LIMIT = INT_W'(64'sd4 <<< FRAC_BITS);
	localparam logic signed [INT_W-1:0] INT_HALF  = INT_W'(64'sd1 <<< (FRAC_BITS - 1));

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_BASE_SPEED        = 3'd0,
		REG_DERIV_GAIN        = 3'd1,
		REG_PROP_GAIN         = 3'd2,
		REG_INTEGRAL_GAIN     = 3'd3,
		REG_LOST_BASE         = 3'd4,
		REG_HYSTERESIS_MARGIN = 3'd5,
		REG_LOST_THRESH_LEFT  = 3'd6,
		REG_LOST_THRESH_RIGHT = 3'd7
	} reg_index_t;

	// Divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* sv/etf_divider.sv */
// ----------------------------------------------------------------------------
// etf_divider: restoring divider for the dwell ratio
// Computes floor(dividend * 2^FRAC_BITS / divisor), one quotient bit a cycle,
// with a single shared subtract-and-compare.
// ----------------------------------------------------------------------------
module etf_divider (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [etf_pkg::TIME_WIDTH-1:0]       dividend,
	input  logic [etf_pkg::TIME_WIDTH:0]         divisor,
	output logic [etf_pkg::QUOT_W-1:0]           quotient,
	output etf_pkg::div_stat_t                   stat
);

	logic [etf_pkg::REM_W-1:0]     rem_q;
	logic [etf_pkg::REM_W-1:0]     div_q;
	logic [etf_pkg::QUOT_W-1:0]    quot_q;
	logic [etf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [etf_pkg::REM_W:0]       diff;
	logic                          take;
	logic [etf_pkg::REM_W-1:0]     rem_sel;

	// Trial subtract: the one arithmetic unit of the loop
	always_comb begin
		diff    = {1'b0, rem_q} - {1'b0, div_q};
		take    = !diff[etf_pkg::REM_W];
		rem_sel = take ? diff[etf_pkg::REM_W-1:0] : rem_q;
	end

	// Load operands, then shift in one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			div_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= etf_pkg::REM_W'(dividend);
				div_q  <= etf_pkg::REM_W'(divisor);
				quot_q <= '0;
				cnt_q  <= etf_pkg::DIV_CNT_W'(etf_pkg::DIV_STEPS - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= {rem_sel[etf_pkg::REM_W-2:0], 1'b0};
				quot_q <= {quot_q[etf_pkg::QUOT_W-2:0], take};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign quotient  = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* sv/edge_tracking_tape_follower_core.sv */
// ----------------------------------------------------------------------------
// edge_tracking_tape_follower_core: tape-edge follower motor controller
// Takes one sensor sample per item and returns the left and right motor
// drives and the edge now being followed.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall) carries one sample: two reflectance
//   readings, two marker bits and a microsecond time. Output channel
//   (out_valid / out_stall) returns one item per sample: both drives,
//   saturated to 16 bits, and the side followed after the sample.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data);
//   write it only while no sample is in flight.
//   Steps: an accepted sample is latched and evaluated, the integral term
//   is multiplied by its gain and the drives are saturated into the output
//   register; at a transition with a non-zero dwell sum the 17-step
//   restoring divider that forms the dwell ratio runs before the multiply.
//   The input is stalled while a sample is being worked on.
//   A finished result waits in the output register; a new sample may be
//   accepted meanwhile, and the sequencer holds its final step until the
//   output register is free.
//   Reset clears all configuration and tracking state (left edge, zero dwell
//   times and integral) and drops out_valid.
// ----------------------------------------------------------------------------
module edge_tracking_tape_follower_core (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// samples
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [9:0]         sensor_left,
	input  logic [9:0]         sensor_right,
	input  logic               mark_left,
	input  logic               mark_right,
	input  logic [31:0]        time_us,
	// results
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] drive_left,
	output logic signed [15:0] drive_right,
	output logic               side_now
);

	localparam int TW     = etf_pkg::TIME_WIDTH;
	localparam int INT_W  = etf_pkg::INT_W;
	localparam int GW     = etf_pkg::GAIN_W;
	localparam int SW     = etf_pkg::SENSOR_W;
	localparam int BASE_W = 20;
	localparam int PROD_W = INT_W + GW;
	localparam int TERM_W = PROD_W - etf_pkg::FRAC_BITS;
	localparam int FIN_W  = 22;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_START,
		ST_DIV,
		ST_MUL,
		ST_FINISH
	} state_t;

	// Configuration registers
	logic signed [GW-1:0] base_speed_q;
	logic signed [GW-1:0] deriv_gain_q;
	logic signed [GW-1:0] prop_gain_q;
	logic signed [GW-1:0] integral_gain_q;
	logic signed [GW-1:0] lost_base_q;
	logic [SW-1:0]        hysteresis_q;
	logic [SW-1:0]        thresh_left_q;
	logic [SW-1:0]        thresh_right_q;

	// Sequencer, sample and tracking state
	state_t                   state_q;
	logic [SW-1:0]            sl_q;
	logic [SW-1:0]            sr_q;
	logic                     ml_q;
	logic                     mr_q;
	logic [TW-1:0]            t_q;
	logic                     side_q;
	logic [TW-1:0]            dwell_left_q;
	logic [TW-1:0]            dwell_right_q;
	logic [TW-1:0]            last_q;
	logic signed [INT_W-1:0]  integral_q;
	logic                     trans_q;
	logic signed [BASE_W-1:0] left_q;
	logic signed [BASE_W-1:0] right_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     out_valid_q;
	logic signed [15:0]       drive_left_q;
	logic signed [15:0]       drive_right_q;
	logic                     side_now_q;

	// Evaluation of one sample
	logic                     side_eff;
	logic                     lost;
	logic                     trans;
	logic [TW-1:0]            dwell_sel;
	logic [TW-1:0]            elapsed;
	logic                     late;
	logic                     mid;
	logic signed [BASE_W-1:0] b_x;
	logic signed [BASE_W-1:0] d_x;
	logic signed [BASE_W-1:0] p_x;
	logic signed [BASE_W-1:0] lb_x;
	logic signed [BASE_W-1:0] nom;
	logic signed [BASE_W-1:0] steer;

	// Divider hookup
	logic [TW:0]                     dwell_sum;
	logic                            div_start;
	logic [etf_pkg::QUOT_W-1:0]      quotient;
	etf_pkg::div_stat_t              div_stat;
	logic signed [INT_W-1:0]         ratio_step;

	// Final step
	logic signed [PROD_W-1:0] prod_adj;
	logic signed [TERM_W-1:0] term;
	logic signed [FIN_W-1:0]  left_fin;
	logic signed [FIN_W-1:0]  right_fin;
	logic                     out_free;

	function automatic logic signed [15:0] sat16(input logic signed [FIN_W-1:0] v);
		logic signed [FIN_W-1:0] hi;
		logic signed [FIN_W-1:0] lo;
		hi = FIN_W'(32'sd32767);
		lo = FIN_W'(-32'sd32768);
		if (v > hi) begin
			return 16'sh7FFF;
		end else if (v < lo) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q    <= '0;
			deriv_gain_q    <= '0;
			prop_gain_q     <= '0;
			integral_gain_q <= '0;
			lost_base_q     <= '0;
			hysteresis_q    <= '0;
			thresh_left_q   <= '0;
			thresh_right_q  <= '0;
		end else if (cfg_write) begin
			case (etf_pkg::reg_index_t'(cfg_index))
				etf_pkg::REG_BASE_SPEED:        base_speed_q    <= cfg_data;
				etf_pkg::REG_DERIV_GAIN:        deriv_gain_q    <= cfg_data;
				etf_pkg::REG_PROP_GAIN:         prop_gain_q     <= cfg_data;
				etf_pkg::REG_INTEGRAL_GAIN:     integral_gain_q <= cfg_data;
				etf_pkg::REG_LOST_BASE:         lost_base_q     <= cfg_data;
				etf_pkg::REG_HYSTERESIS_MARGIN: hysteresis_q    <= cfg_data[SW-1:0];
				etf_pkg::REG_LOST_THRESH_LEFT:  thresh_left_q   <= cfg_data[SW-1:0];
				etf_pkg::REG_LOST_THRESH_RIGHT: thresh_right_q  <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// Decide the case for the latched sample. The right-edge drives are the
	// left-edge drives with the motors swapped, so form nominal +/- steering.
	always_comb begin
		side_eff  = ml_q ? 1'b1 : (mr_q ? 1'b0 : side_q);
		lost      = (sl_q < thresh_left_q) && (sr_q < thresh_right_q);
		if (side_eff) begin
			trans = !lost && (({1'b0, sl_q} + {1'b0, hysteresis_q}) < {1'b0, sr_q});
		end else begin
			trans = !lost && (({1'b0, sr_q} + {1'b0, hysteresis_q}) < {1'b0, sl_q});
		end
		dwell_sel = side_eff ? dwell_right_q : dwell_left_q;
		elapsed   = t_q - last_q;
		late      = t_q > (last_q + dwell_sel);
		mid       = t_q > (last_q + (dwell_sel >> 1));
		b_x       = BASE_W'(base_speed_q);
		d_x       = BASE_W'(deriv_gain_q);
		p_x       = BASE_W'(prop_gain_q);
		lb_x      = BASE_W'(lost_base_q);
		if (lost) begin
			nom   = lb_x;
			steer = -(p_x <<< 1);
		end else if (trans) begin
			nom   = b_x;
			steer = d_x + p_x;
		end else if (late) begin
			nom   = b_x;
			steer = -p_x;
		end else if (mid) begin
			nom   = b_x;
			steer = d_x - p_x;
		end else begin
			nom   = b_x;
			steer = -(d_x + p_x);
		end
	end

	// Kick the divider only at a transition with a non-zero dwell sum
	always_comb begin
		dwell_sum  = {1'b0, dwell_left_q} + {1'b0, dwell_right_q};
		div_start  = (state_q == ST_START) && trans_q && (dwell_sum != '0);
		ratio_step = $signed(INT_W'(quotient)) - etf_pkg::INT_HALF;
	end

	etf_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dwell_left_q),
		.divisor  (dwell_sum),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// Integral term truncated toward zero, then the exact drive sums
	always_comb begin
		prod_adj  = prod_q + (prod_q[PROD_W-1] ?
			PROD_W'((64'sd1 <<< etf_pkg::FRAC_BITS) - 64'sd1) : PROD_W'(0));
		term      = TERM_W'(prod_adj >>> etf_pkg::FRAC_BITS);
		left_fin  = FIN_W'(left_q) - FIN_W'(term);
		right_fin = FIN_W'(right_q) + FIN_W'(term);
		out_free  = !out_valid_q || !out_stall;
	end

	// Sequencer with tracking state and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sl_q          <= '0;
			sr_q          <= '0;
			ml_q          <= 1'b0;
			mr_q          <= 1'b0;
			t_q           <= '0;
			side_q        <= 1'b0;
			dwell_left_q  <= '0;
			dwell_right_q <= '0;
			last_q        <= '0;
			integral_q    <= '0;
			trans_q       <= 1'b0;
			left_q        <= '0;
			right_q       <= '0;
			prod_q        <= '0;
			out_valid_q   <= 1'b0;
			drive_left_q  <= '0;
			drive_right_q <= '0;
			side_now_q    <= 1'b0;
		end else begin
			// drop a result once it is taken, unless the final step refills it
			if (out_valid_q && !out_stall && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sl_q    <= sensor_left;
						sr_q    <= sensor_right;
						ml_q    <= mark_left;
						mr_q    <= mark_right;
						t_q     <= time_us[TW-1:0];
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					trans_q <= trans;
					left_q  <= side_eff ? (nom + steer) : (nom - steer);
					right_q <= side_eff ? (nom - steer) : (nom + steer);
					if (trans) begin
						last_q <= t_q;
						side_q <= !side_eff;
						if (side_eff) begin
							dwell_right_q <= elapsed;
						end else begin
							dwell_left_q <= elapsed;
						end
					end else begin
						side_q <= side_eff;
					end
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= div_start ? ST_DIV : ST_MUL;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						integral_q <= integral_q + ratio_step;
						state_q    <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(integral_q) * PROD_W'(integral_gain_q);
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						drive_left_q  <= sat16(left_fin);
						drive_right_q <= sat16(right_fin);
						side_now_q    <= side_q;
						out_valid_q   <= 1'b1;
						if (integral_q > etf_pkg::INT_LIMIT) begin
							integral_q <= etf_pkg::INT_LIMIT;
						end else if (integral_q < -etf_pkg::INT_LIMIT) begin
							integral_q <= -etf_pkg::INT_LIMIT;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign drive_left  = drive_left_q;
	assign drive_right = drive_right_q;
	assign side_now    = side_now_q;

`ifndef NO_ASSERTIONS
	// A new result appears only from the final step
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the final step");

	// Integral is back within limits whenever the block is idle
	a_integral_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |->
			(integral_q <= etf_pkg::INT_LIMIT) && (integral_q >= -etf_pkg::INT_LIMIT))
		else $error("balance integral out of range while idle");

	// While waiting on the divider it must be working or finishing
	a_div_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_stat.busy || div_stat.done))
		else $error("sequencer waits on an idle divider");

	// Divider completion is a single-cycle pulse
	a_div_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |=> !div_stat.done)
		else $error("divider done held for more than one cycle");
`endif

endmodule

/* test/edge_tracking_tape_follower_checker.sv */
// ----------------------------------------------------------------------------
// edge_tracking_tape_follower_checker: result predictor and comparator
// Watches the configuration port and both item channels of the tape
// follower, predicts the drives and side for every accepted sample and
// compares each returned item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module edge_tracking_tape_follower_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [9:0]         sensor_left,
	input  logic [9:0]         sensor_right,
	input  logic               mark_left,
	input  logic               mark_right,
	input  logic [31:0]        time_us,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] drive_left,
	input  logic signed [15:0] drive_right,
	input  logic               side_now,
	output int                 mismatch_count,
	output int                 pending_results,
	output int                 results_checked,
	output int                 transitions_seen,
	output int                 lost_seen,
	output int                 clamps_seen
);

	localparam longint FX_ONE = longint'(1) << etf_pkg::FRAC_BITS;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               side;
	} drive_t;

	// Local copy of the configuration
	logic signed [etf_pkg::GAIN_W-1:0] cruise_drive = '0;
	logic signed [etf_pkg::GAIN_W-1:0] weave_gain   = '0;
	logic signed [etf_pkg::GAIN_W-1:0] steer_gain   = '0;
	logic signed [etf_pkg::GAIN_W-1:0] balance_gain = '0;
	logic signed [etf_pkg::GAIN_W-1:0] search_drive = '0;
	logic [etf_pkg::SENSOR_W-1:0]      cross_margin = '0;
	logic [etf_pkg::SENSOR_W-1:0]      floor_left   = '0;
	logic [etf_pkg::SENSOR_W-1:0]      floor_right  = '0;

	// Local copy of the tracking state
	logic                              edge_side      = 1'b0;
	logic [etf_pkg::TIME_WIDTH-1:0]    dwell_on_left  = '0;
	logic [etf_pkg::TIME_WIDTH-1:0]    dwell_on_right = '0;
	logic [etf_pkg::TIME_WIDTH-1:0]    last_cross     = '0;
	logic signed [etf_pkg::INT_W-1:0]  balance_acc    = '0;

	drive_t drive_expect_q[$];

	function automatic logic signed [15:0] clip_drive(input longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// Advance the tracking state by one sample and queue the drives it yields
	task automatic predict_sample(input logic [etf_pkg::SENSOR_W-1:0] sl,
			input logic [etf_pkg::SENSOR_W-1:0] sr,
			input logic ml, input logic mr, input logic [etf_pkg::TIME_WIDTH-1:0] t);
		longint                         lv, rv, margin, steer, centre, prod, term, acc, lft, rgt;
		logic [etf_pkg::TIME_WIDTH-1:0] dwell_now, full_end, half_end;
		logic [etf_pkg::TIME_WIDTH:0]   dwell_sum;
		logic [63:0]                    ratio;
		logic                           lost, toward_left;
		drive_t                         want;
		lv     = longint'(sl);
		rv     = longint'(sr);
		margin = longint'(cross_margin);
		lost   = (sl < floor_left) && (sr < floor_right);

		// Markers override the edge; left marker wins
		if (ml)
			edge_side = 1'b1;
		else if (mr)
			edge_side = 1'b0;

		toward_left = !edge_side;
		dwell_now   = edge_side ? dwell_on_right : dwell_on_left;
		full_end    = last_cross + dwell_now;
		half_end    = last_cross + (dwell_now >> 1);
		centre      = longint'(cruise_drive);
		acc         = longint'(balance_acc);

		if (lost) begin
			centre = longint'(search_drive);
			steer  = 2 * longint'(steer_gain);
			lost_seen <= lost_seen + 1;
		end else if (edge_side ? (lv + margin < rv) : (rv + margin < lv)) begin
			// Side change: record dwell, fold the dwell ratio into the integral
			steer = -longint'(weave_gain) - longint'(steer_gain);
			if (edge_side)
				dwell_on_right = t - last_cross;
			else
				dwell_on_left = t - last_cross;
			last_cross = t;
			dwell_sum  = {1'b0, dwell_on_left} + {1'b0, dwell_on_right};
			if (dwell_sum != 0) begin
				ratio = (64'(dwell_on_left) << etf_pkg::FRAC_BITS) / 64'(dwell_sum);
				acc   = acc + longint'(ratio) - FX_ONE / 2;
			end
			edge_side = ~edge_side;
			transitions_seen <= transitions_seen + 1;
		end else if (t > full_end) begin
			steer = longint'(steer_gain);
		end else if (t > half_end) begin
			steer = longint'(steer_gain) - longint'(weave_gain);
		end else begin
			steer = longint'(weave_gain) + longint'(steer_gain);
		end

		lft = toward_left ? centre + steer : centre - steer;
		rgt = toward_left ? centre - steer : centre + steer;

		// Integral term uses the unclamped value, truncated toward zero
		prod = acc * longint'(balance_gain);
		term = prod / FX_ONE;
		lft  = lft - term;
		rgt  = rgt + term;

		if (acc > longint'(etf_pkg::INT_LIMIT)) begin
			acc = longint'(etf_pkg::INT_LIMIT);
			clamps_seen <= clamps_seen + 1;
		end else if (acc < -longint'(etf_pkg::INT_LIMIT)) begin
			acc = -longint'(etf_pkg::INT_LIMIT);
			clamps_seen <= clamps_seen + 1;
		end
		balance_acc = acc[etf_pkg::INT_W-1:0];

		want.left  = clip_drive(lft);
		want.right = clip_drive(rgt);
		want.side  = edge_side;
		drive_expect_q.push_back(want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_t got, want;
		if (!arst_n) begin
			cruise_drive   = '0;
			weave_gain     = '0;
			steer_gain     = '0;
			balance_gain   = '0;
			search_drive   = '0;
			cross_margin   = '0;
			floor_left     = '0;
			floor_right    = '0;
			edge_side      = 1'b0;
			dwell_on_left  = '0;
			dwell_on_right = '0;
			last_cross     = '0;
			balance_acc    = '0;
			drive_expect_q.delete();
			pending_results <= 0;
		end else begin
			// Track register writes
			if (cfg_write) begin
				case (etf_pkg::reg_index_t'(cfg_index))
					etf_pkg::REG_BASE_SPEED:        cruise_drive = cfg_data;
					etf_pkg::REG_DERIV_GAIN:        weave_gain   = cfg_data;
					etf_pkg::REG_PROP_GAIN:         steer_gain   = cfg_data;
					etf_pkg::REG_INTEGRAL_GAIN:     balance_gain = cfg_data;
					etf_pkg::REG_LOST_BASE:         search_drive = cfg_data;
					etf_pkg::REG_HYSTERESIS_MARGIN:
						cross_margin = cfg_data[etf_pkg::SENSOR_W-1:0];
					etf_pkg::REG_LOST_THRESH_LEFT:
						floor_left = cfg_data[etf_pkg::SENSOR_W-1:0];
					etf_pkg::REG_LOST_THRESH_RIGHT:
						floor_right = cfg_data[etf_pkg::SENSOR_W-1:0];
					default: ;
				endcase
			end

			// Compare a returned item against the oldest prediction
			if (out_valid && !out_stall) begin
				got.left  = drive_left;
				got.right = drive_right;
				got.side  = side_now;
				if (drive_expect_q.size() == 0) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < 10)
						$display("unexpected result item: left %0d right %0d side %0b",
							got.left, got.right, got.side);
				end else begin
					want = drive_expect_q.pop_front();
					if (got.left !== want.left || got.right !== want.right ||
							got.side !== want.side) begin
						mismatch_count <= mismatch_count + 1;
						if (mismatch_count < 10)
							$display({"result %0d differs: expected left %0d right %0d ",
								"side %0b, got left %0d right %0d side %0b"},
								results_checked, want.left, want.right, want.side,
								got.left, got.right, got.side);
					end
				end
				results_checked <= results_checked + 1;
			end

			if (in_valid && !in_stall)
				predict_sample(sensor_left, sensor_right, mark_left, mark_right, time_us);

			pending_results <= drive_expect_q.size();
		end
	end

endmodule

/* test/edge_tracking_tape_follower_core_tb.sv */
// ----------------------------------------------------------------------------
// edge_tracking_tape_follower_core_tb: stimulus and verdict
// Drives directed samples (transitions, lost tape, markers, time wrap,
// integral clamp) and then phases of random tape-following sequences under
// several register settings and stall patterns; a checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module edge_tracking_tape_follower_core_tb;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 200;

	typedef enum logic [1:0] {
		PAT_LEFT_HIGH,
		PAT_RIGHT_HIGH,
		PAT_LOST,
		PAT_NOISE
	} sample_shape_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_write    = 1'b0;
	logic [2:0]         cfg_index    = '0;
	logic [15:0]        cfg_data     = '0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [9:0]         sensor_left  = '0;
	logic [9:0]         sensor_right = '0;
	logic               mark_left    = 1'b0;
	logic               mark_right   = 1'b0;
	logic [31:0]        time_us      = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic signed [15:0] drive_left;
	logic signed [15:0] drive_right;
	logic               side_now;

	int mismatch_count, pending_results, results_checked;
	int transitions_seen, lost_seen, clamps_seen;

	int            send_idle_pct  = 0;
	int            recv_idle_pct  = 0;
	int            hold_requests  = 0;
	int            hold_taken     = 0;
	int            hold_left      = 0;
	int            quiet_cycles   = 0;
	int            samples_sent   = 0;
	int            settings_used  = 0;
	logic [15:0]   cfg_vals [0:7];
	logic [31:0]   sample_time    = '0;
	sample_shape_t shape          = PAT_LEFT_HIGH;

	edge_tracking_tape_follower_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sensor_left  (sensor_left),
		.sensor_right (sensor_right),
		.mark_left    (mark_left),
		.mark_right   (mark_right),
		.time_us      (time_us),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive_left   (drive_left),
		.drive_right  (drive_right),
		.side_now     (side_now)
	);

	edge_tracking_tape_follower_checker drive_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sensor_left      (sensor_left),
		.sensor_right     (sensor_right),
		.mark_left        (mark_left),
		.mark_right       (mark_right),
		.time_us          (time_us),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.drive_left       (drive_left),
		.drive_right      (drive_right),
		.side_now         (side_now),
		.mismatch_count   (mismatch_count),
		.pending_results  (pending_results),
		.results_checked  (results_checked),
		.transitions_seen (transitions_seen),
		.lost_seen        (lost_seen),
		.clamps_seen      (clamps_seen)
	);

	always #5 clk = ~clk;

	// Receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_taken != hold_requests) begin
			hold_taken = hold_requests;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Watchdog: count cycles in which no item moves on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// Offer one sample and hold it until accepted
	task automatic send_sample(input logic [9:0] sl, input logic [9:0] sr,
			input logic ml, input logic mr, input logic [31:0] t);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		sensor_left  <= sl;
		sensor_right <= sr;
		mark_left    <= ml;
		mark_right   <= mr;
		time_us      <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		samples_sent++;
	endtask

	// Drop valid and wait until every predicted item has returned
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results != 0);
	endtask

	// Write every register from cfg_vals
	task automatic program_settings();
		etf_pkg::reg_index_t ri;
		ri = ri.first();
		repeat (ri.num()) begin
			cfg_write <= 1'b1;
			cfg_index <= ri;
			cfg_data  <= cfg_vals[ri];
			@(posedge clk);
			ri = ri.next();
		end
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	// Random gains; margins and thresholds kept low so transitions occur,
	// with the bits above the register width set at random
	task automatic pick_random_settings();
		cfg_vals[etf_pkg::REG_BASE_SPEED]        = 16'($urandom);
		cfg_vals[etf_pkg::REG_DERIV_GAIN]        = 16'($urandom);
		cfg_vals[etf_pkg::REG_PROP_GAIN]         = 16'($urandom);
		cfg_vals[etf_pkg::REG_INTEGRAL_GAIN]     = 16'($urandom);
		cfg_vals[etf_pkg::REG_LOST_BASE]         = 16'($urandom);
		cfg_vals[etf_pkg::REG_HYSTERESIS_MARGIN] =
			{6'($urandom), 10'($urandom_range(0, 150))};
		cfg_vals[etf_pkg::REG_LOST_THRESH_LEFT]  =
			{6'($urandom), 10'($urandom_range(0, 350))};
		cfg_vals[etf_pkg::REG_LOST_THRESH_RIGHT] =
			{6'($urandom), 10'($urandom_range(0, 350))};
	endtask

	task automatic pick_extreme_settings(input logic high_end);
		cfg_vals[etf_pkg::REG_BASE_SPEED]        = high_end ? 16'h7FFF : 16'h8000;
		cfg_vals[etf_pkg::REG_DERIV_GAIN]        = high_end ? 16'h7FFF : 16'h8000;
		cfg_vals[etf_pkg::REG_PROP_GAIN]         = high_end ? 16'h7FFF : 16'h8000;
		cfg_vals[etf_pkg::REG_INTEGRAL_GAIN]     = high_end ? 16'h7FFF : 16'h8000;
		cfg_vals[etf_pkg::REG_LOST_BASE]         = high_end ? 16'h7FFF : 16'h8000;
		cfg_vals[etf_pkg::REG_HYSTERESIS_MARGIN] = high_end ? 16'hFFFF : 16'h0000;
		cfg_vals[etf_pkg::REG_LOST_THRESH_LEFT]  = high_end ? 16'hFFFF : 16'h0000;
		cfg_vals[etf_pkg::REG_LOST_THRESH_RIGHT] = high_end ? 16'hFFFF : 16'h0000;
	endtask

	// Runs of alternating tape sides with random timing, some lost tape,
	// some noise; lean shortens one side's runs to push the integral
	task automatic run_random_phase(input int count, input int lean,
			input bit with_hold, input bit with_pause);
		int          run_left, pick;
		logic [9:0]  sl, sr, floor_l, floor_r;
		logic        ml, mr;
		run_left = 0;
		floor_l  = cfg_vals[etf_pkg::REG_LOST_THRESH_LEFT][9:0];
		floor_r  = cfg_vals[etf_pkg::REG_LOST_THRESH_RIGHT][9:0];
		for (int n = 0; n < count; n++) begin
			if (with_hold && n == 20)
				hold_requests++;
			if (with_pause && n == 40)
				drain_results();

			// Choose the next sensor pattern and its run length
			if (run_left == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					shape = (shape == PAT_LEFT_HIGH) ? PAT_RIGHT_HIGH : PAT_LEFT_HIGH;
				else if (pick < 88)
					shape = PAT_LOST;
				else
					shape = PAT_NOISE;
				if ((lean == 1 && shape == PAT_LEFT_HIGH) ||
						(lean == 2 && shape == PAT_RIGHT_HIGH))
					run_left = 1;
				else
					run_left = $urandom_range(1, 6);
			end
			run_left--;

			case (shape)
				PAT_LEFT_HIGH: begin
					sl = 10'($urandom_range(600, 1023));
					sr = 10'($urandom_range(0, 400));
				end
				PAT_RIGHT_HIGH: begin
					sl = 10'($urandom_range(0, 400));
					sr = 10'($urandom_range(600, 1023));
				end
				PAT_LOST: begin
					sl = (floor_l == 0) ? 10'd0 : 10'($urandom_range(0, floor_l - 1));
					sr = (floor_r == 0) ? 10'd0 : 10'($urandom_range(0, floor_r - 1));
				end
				default: begin
					sl = 10'($urandom_range(0, 1023));
					sr = 10'($urandom_range(0, 1023));
				end
			endcase

			// Advance time: mostly small steps, some repeats, jumps and wraps
			pick = $urandom_range(0, 99);
			if (pick < 80)
				sample_time = sample_time + $urandom_range(1, 3000);
			else if (pick < 86)
				sample_time = sample_time;
			else if (pick < 93)
				sample_time = $urandom;
			else
				sample_time = 32'hFFFF_FFFF - $urandom_range(0, 3000);

			ml = ($urandom_range(0, 99) < 6);
			mr = ($urandom_range(0, 99) < 6);
			send_sample(sl, sr, ml, mr, sample_time);
		end
	endtask

	initial begin
		logic [31:0] t_dir;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 27;
		recv_idle_pct = 57;

		// Moderate settings for the directed part
		cfg_vals[etf_pkg::REG_BASE_SPEED]        = 16'd1000;
		cfg_vals[etf_pkg::REG_DERIV_GAIN]        = 16'd300;
		cfg_vals[etf_pkg::REG_PROP_GAIN]         = 16'd200;
		cfg_vals[etf_pkg::REG_INTEGRAL_GAIN]     = 16'd20000;
		cfg_vals[etf_pkg::REG_LOST_BASE]         = -16'sd500;
		cfg_vals[etf_pkg::REG_HYSTERESIS_MARGIN] = 16'd50;
		cfg_vals[etf_pkg::REG_LOST_THRESH_LEFT]  = 16'd100;
		cfg_vals[etf_pkg::REG_LOST_THRESH_RIGHT] = 16'd100;
		program_settings();

		// Transition straight after reset: zero dwell sum
		send_sample(10'd1023, 10'd0, 1'b0, 1'b0, 32'd0);
		send_sample(10'd0, 10'd1023, 1'b0, 1'b0, 32'd1000);
		send_sample(10'd1023, 10'd0, 1'b0, 1'b0, 32'd1500);
		// Tape lost, then early, mid and late in the dwell window
		send_sample(10'd0, 10'd0, 1'b0, 1'b0, 32'd1600);
		send_sample(10'd500, 10'd500, 1'b0, 1'b0, 32'd1700);
		send_sample(10'd500, 10'd500, 1'b0, 1'b0, 32'd2200);
		send_sample(10'd500, 10'd500, 1'b0, 1'b0, 32'd2600);
		// Markers: both set (left wins), then right alone, then left alone
		send_sample(10'd500, 10'd500, 1'b1, 1'b1, 32'd2700);
		send_sample(10'd500, 10'd500, 1'b0, 1'b1, 32'd2800);
		send_sample(10'd1023, 10'd1023, 1'b0, 1'b1, 32'hFFFF_FFFF);
		send_sample(10'd0, 10'd0, 1'b1, 1'b0, 32'd0);
		// Transitions across the time wrap, then a wrapped window test
		send_sample(10'd1023, 10'd0, 1'b0, 1'b1, 32'hFFFF_FF00);
		send_sample(10'd0, 10'd1023, 1'b0, 1'b0, 32'h0000_0100);
		send_sample(10'd512, 10'd512, 1'b0, 1'b0, 32'h0000_0180);
		// Sensor difference exactly at the margin: no transition
		send_sample(10'd150, 10'd100, 1'b0, 1'b0, 32'h0000_0190);
		// Lopsided dwell times drive the integral into its clamp
		t_dir = 32'h0000_0200;
		repeat (5) begin
			send_sample(10'd1023, 10'd0, 1'b0, 1'b0, t_dir);
			t_dir = t_dir + 20000;
			send_sample(10'd0, 10'd1023, 1'b0, 1'b0, t_dir);
			t_dir = t_dir + 1;
		end
		sample_time = t_dir;
		drain_results();

		// Random phases under changing settings and stall patterns
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 2) begin
				send_idle_pct = 57;
				recv_idle_pct = 27;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (phase == 1)
				pick_extreme_settings(1'b1);
			else if (phase == 2)
				pick_extreme_settings(1'b0);
			else
				pick_random_settings();
			program_settings();
			run_random_phase(88, (phase == 3) ? 1 : (phase == 4) ? 2 : 0,
				phase == 1, phase == 2);
			drain_results();
		end

		// Let any stray result item show up
		repeat (30) @(posedge clk);

		$display("Sent %0d samples under %0d register settings, %0d result items compared.",
			samples_sent, settings_used, results_checked);
		$display("Covered %0d side transitions, %0d lost-tape samples, %0d integral clamps.",
			transitions_seen, lost_seen, clamps_seen);
		if (mismatch_count == 0 && pending_results == 0) begin
			$display("No mismatches found");
		end else begin
			if (pending_results != 0)
				$display("%0d predicted result items never returned", pending_results);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
